@@ design/flash_block_allocator_macros.svh @@
// ----------------------------------------------------------------------------
// Flash block allocator assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FLASH_BLOCK_ALLOCATOR_MACROS_SVH
`define FLASH_BLOCK_ALLOCATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FBA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FBA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/fba_pkg.sv @@
// ----------------------------------------------------------------------------
// Flash block allocator package
// Field widths, codes and the command and status bundles of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fba_pkg;

	localparam int ENTRIES_DEF = 512;
	localparam int POOLS_DEF   = 4;

	localparam int KIND_W = 3;
	localparam int POOL_W = 2;
	localparam int IDX_W  = 9;
	localparam int STAT_W = 3;
	localparam int BS_W   = 2;
	localparam int SRC_W  = 2;

	// Item kinds.
	localparam logic [KIND_W-1:0] K_ALLOC      = 3'd0;
	localparam logic [KIND_W-1:0] K_ERASE_RPLY = 3'd1;
	localparam logic [KIND_W-1:0] K_RELEASE    = 3'd2;
	localparam logic [KIND_W-1:0] K_QUERY      = 3'd3;
	localparam logic [KIND_W-1:0] K_SET_STATE  = 3'd4;
	localparam logic [KIND_W-1:0] K_SET_CURSOR = 3'd5;

	// Block states.
	localparam logic [BS_W-1:0] BS_FREE     = 2'd0;
	localparam logic [BS_W-1:0] BS_OPEN     = 2'd1;
	localparam logic [BS_W-1:0] BS_RESERVED = 2'd2;
	localparam logic [BS_W-1:0] BS_BAD      = 2'd3;

	// Result status codes.
	localparam logic [STAT_W-1:0] RES_GRANTED  = 3'd0;
	localparam logic [STAT_W-1:0] RES_ERASE    = 3'd1;
	localparam logic [STAT_W-1:0] RES_OUT      = 3'd2;
	localparam logic [STAT_W-1:0] RES_RELEASED = 3'd3;
	localparam logic [STAT_W-1:0] RES_RESV     = 3'd4;
	localparam logic [STAT_W-1:0] RES_NOTRESV  = 3'd5;
	localparam logic [STAT_W-1:0] RES_WRITTEN  = 3'd6;
	localparam logic [STAT_W-1:0] RES_REJECT   = 3'd7;

	// Where the pool and index of a result come from.
	localparam logic [SRC_W-1:0] SRC_ITEM    = 2'd0;
	localparam logic [SRC_W-1:0] SRC_PENDING = 2'd1;
	localparam logic [SRC_W-1:0] SRC_PROBE   = 2'd2;
	localparam logic [SRC_W-1:0] SRC_EMPTY   = 2'd3;

	typedef struct packed {
		logic              load_item;
		logic              clear_step;
		logic              erase_done;
		logic              walk_start;
		logic              item_write;
		logic              item_read;
		logic              probe_issue;
		logic              probe_grant;
		logic              probe_erase;
		logic              mod_start;
		logic              mod_step;
		logic              res_load;
		logic [STAT_W-1:0] res_status;
		logic [SRC_W-1:0]  res_src;
		logic              out_load;
	} cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              pool_ok;
		logic              idx_ok;
		logic              awaiting;
		logic              erase_ok;
		logic              probes_full;
		logic [BS_W-1:0]   rd_state;
		logic              mod_last;
		logic              clear_last;
	} stat_t;

endpackage

@@ design/fba_ctrl.sv @@
// ----------------------------------------------------------------------------
// Flash block allocator controller
// Sequences decode, pool walks, the cursor reduction and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "flash_block_allocator_macros.svh"

module fba_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  fba_pkg::stat_t stat,
	output fba_pkg::cmd_t  cmd
);
	import fba_pkg::*;

	localparam logic [2:0] S_CLEAR     = 3'd0;
	localparam logic [2:0] S_IDLE      = 3'd1;
	localparam logic [2:0] S_DECODE    = 3'd2;
	localparam logic [2:0] S_PROBE_RD  = 3'd3;
	localparam logic [2:0] S_PROBE_CHK = 3'd4;
	localparam logic [2:0] S_QUERY     = 3'd5;
	localparam logic [2:0] S_MOD       = 3'd6;
	localparam logic [2:0] S_RESULT    = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (stat.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.res_src    = SRC_ITEM;
				cmd.res_status = RES_REJECT;
				if (stat.kind == K_ERASE_RPLY) begin
					if (!stat.awaiting) begin
						cmd.res_load = 1'b1;
						state_d      = S_RESULT;
					end else begin
						cmd.erase_done = 1'b1;
						if (stat.erase_ok) begin
							cmd.res_load   = 1'b1;
							cmd.res_status = RES_GRANTED;
							cmd.res_src    = SRC_PENDING;
							state_d        = S_RESULT;
						end else begin
							state_d = S_PROBE_RD;
						end
					end
				end else if (!stat.pool_ok || stat.kind > K_SET_CURSOR) begin
					cmd.res_load = 1'b1;
					state_d      = S_RESULT;
				end else if (stat.kind == K_ALLOC) begin
					if (stat.awaiting) begin
						cmd.res_load = 1'b1;
						state_d      = S_RESULT;
					end else begin
						cmd.walk_start = 1'b1;
						state_d        = S_PROBE_RD;
					end
				end else if (stat.kind == K_SET_CURSOR) begin
					cmd.mod_start = 1'b1;
					state_d       = S_MOD;
				end else if (!stat.idx_ok) begin
					cmd.res_load = 1'b1;
					state_d      = S_RESULT;
				end else if (stat.kind == K_QUERY) begin
					cmd.item_read = 1'b1;
					state_d       = S_QUERY;
				end else begin
					cmd.item_write = 1'b1;
					cmd.res_load   = 1'b1;
					cmd.res_status = (stat.kind == K_RELEASE) ? RES_RELEASED : RES_WRITTEN;
					state_d        = S_RESULT;
				end
			end
			S_PROBE_RD: begin
				if (stat.probes_full) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = RES_OUT;
					cmd.res_src    = SRC_EMPTY;
					state_d        = S_RESULT;
				end else begin
					cmd.probe_issue = 1'b1;
					state_d         = S_PROBE_CHK;
				end
			end
			S_PROBE_CHK: begin
				cmd.res_src = SRC_PROBE;
				if (stat.rd_state == BS_OPEN) begin
					cmd.probe_grant = 1'b1;
					cmd.res_load    = 1'b1;
					cmd.res_status  = RES_GRANTED;
					state_d         = S_RESULT;
				end else if (stat.rd_state == BS_FREE) begin
					cmd.probe_erase = 1'b1;
					cmd.res_load    = 1'b1;
					cmd.res_status  = RES_ERASE;
					state_d         = S_RESULT;
				end else begin
					state_d = S_PROBE_RD;
				end
			end
			S_QUERY: begin
				cmd.res_load   = 1'b1;
				cmd.res_src    = SRC_ITEM;
				cmd.res_status = (stat.rd_state == BS_RESERVED) ? RES_RESV : RES_NOTRESV;
				state_d        = S_RESULT;
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (stat.mod_last) begin
					cmd.res_load   = 1'b1;
					cmd.res_src    = SRC_ITEM;
					cmd.res_status = RES_WRITTEN;
					state_d        = S_RESULT;
				end
			end
			S_RESULT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`FBA_ASSERT_NOW(a_load_only_when_free, cmd.out_load, !out_valid_q || out_ready, "result overwritten")
	`FBA_ASSERT_NEXT(a_accept_to_decode, in_valid && in_ready, state_q == S_DECODE, "accept lost")
	`FBA_ASSERT_NEXT(a_clear_only_once, state_q != S_CLEAR, state_q != S_CLEAR, "clear restarted")
	`FBA_ASSERT_NOW(a_valid_from_result, $rose(out_valid_q), $past(state_q) == S_RESULT, "stray result")

endmodule

@@ design/fba_datapath.sv @@
// ----------------------------------------------------------------------------
// Flash block allocator datapath
// Block state memory, pool cursors, erase bookkeeping and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fba_datapath #(
	parameter int ENTRIES = fba_pkg::ENTRIES_DEF,
	parameter int POOLS   = fba_pkg::POOLS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fba_pkg::cmd_t                cmd,
	output fba_pkg::stat_t               stat,
	input  logic [fba_pkg::KIND_W-1:0]   kind,
	input  logic [fba_pkg::POOL_W-1:0]   pool,
	input  logic [fba_pkg::IDX_W-1:0]    index,
	input  logic                         erase_ok,
	input  logic [fba_pkg::BS_W-1:0]     new_state,
	output logic [fba_pkg::STAT_W-1:0]   status,
	output logic [fba_pkg::POOL_W-1:0]   out_pool,
	output logic [fba_pkg::IDX_W-1:0]    out_index
);
	import fba_pkg::*;

	localparam int CW     = $clog2(ENTRIES);
	localparam int PRW    = $clog2(ENTRIES + 1);
	localparam int DEPTH  = POOLS * ENTRIES;
	localparam int AW     = $clog2(DEPTH);
	localparam int PW     = (POOLS > 1) ? $clog2(POOLS) : 1;
	localparam int MODK_W = 1;
	// Reciprocal of ENTRIES scaled by 2^RCP_SH; wide enough that the quotient
	// estimate of any 9-bit index is at most one short.
	localparam int RCP_SH = IDX_W + 13;
	localparam int PROD_W = IDX_W + RCP_SH;
	localparam logic [RCP_SH-1:0] RCP_M = RCP_SH'((64'd1 << RCP_SH) / 64'(ENTRIES));

	// Latched input item.
	logic [KIND_W-1:0] item_kind_q;
	logic [POOL_W-1:0] item_pool_q;
	logic [IDX_W-1:0]  item_index_q;
	logic              item_ok_q;
	logic [BS_W-1:0]   item_ns_q;

	logic [CW-1:0]     cursor_q [POOLS];
	logic              awaiting_q;
	logic [POOL_W-1:0] pending_pool_q;
	logic [CW-1:0]     pending_index_q;
	logic [PRW-1:0]    probes_q;
	logic [POOL_W-1:0] walk_pool_q;
	logic [CW-1:0]     probe_idx_q;
	logic [AW-1:0]     clr_q;
	logic [IDX_W-1:0]  mod_quo_q;
	logic [IDX_W-1:0]  mod_rem_q;
	logic [MODK_W-1:0] mod_k_q;

	logic [BS_W-1:0]   mem_q [DEPTH];
	logic [BS_W-1:0]   rdata_q;

	logic [STAT_W-1:0] res_status_q;
	logic [POOL_W-1:0] res_pool_q;
	logic [IDX_W-1:0]  res_index_q;
	logic [STAT_W-1:0] out_status_q;
	logic [POOL_W-1:0] out_pool_q;
	logic [IDX_W-1:0]  out_index_q;

	logic [PW-1:0]     walk_sel;
	logic [CW-1:0]     cur_idx;
	logic [CW-1:0]     cur_next;
	logic [AW-1:0]     item_addr;
	logic [AW-1:0]     probe_addr;
	logic [AW-1:0]     grant_addr;
	logic [AW-1:0]     pend_addr;
	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	logic [BS_W-1:0]   mem_wd;
	logic              mem_re;
	logic [AW-1:0]     mem_ra;
	logic [PROD_W-1:0] mod_prod;
	logic [31:0]       mod_back;
	logic [IDX_W-1:0]  mod_fix;

	function automatic logic [AW-1:0] slot(input logic [POOL_W-1:0] p, input logic [AW-1:0] i);
		return AW'(AW'(p) * AW'(ENTRIES) + i);
	endfunction

	assign walk_sel   = PW'(walk_pool_q);
	assign cur_idx    = cursor_q[walk_sel];
	assign cur_next   = (cur_idx == CW'(ENTRIES - 1)) ? '0 : CW'(cur_idx + 1'b1);
	assign item_addr  = slot(item_pool_q, AW'(item_index_q));
	assign probe_addr = slot(walk_pool_q, AW'(cur_idx));
	assign grant_addr = slot(walk_pool_q, AW'(probe_idx_q));
	assign pend_addr  = slot(pending_pool_q, AW'(pending_index_q));

	// Cursor reduction: quotient estimate by reciprocal multiplication, then the
	// remainder, then one conditional subtract for an estimate that came up short.
	assign mod_prod = PROD_W'(item_index_q) * PROD_W'(RCP_M);
	assign mod_back = 32'(mod_quo_q) * 32'(ENTRIES);
	assign mod_fix  = (32'(mod_rem_q) >= 32'(ENTRIES)) ? IDX_W'(32'(mod_rem_q) - 32'(ENTRIES))
	                                                   : mod_rem_q;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = item_addr;
		mem_wd = BS_FREE;
		if (cmd.clear_step) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
		end else if (cmd.erase_done) begin
			mem_we = 1'b1;
			mem_wa = pend_addr;
			mem_wd = item_ok_q ? BS_RESERVED : BS_BAD;
		end else if (cmd.item_write) begin
			mem_we = 1'b1;
			mem_wd = (item_kind_q == K_RELEASE) ? BS_FREE : item_ns_q;
		end else if (cmd.probe_grant) begin
			mem_we = 1'b1;
			mem_wa = grant_addr;
			mem_wd = BS_RESERVED;
		end
	end

	assign mem_re = cmd.probe_issue || cmd.item_read;
	assign mem_ra = cmd.probe_issue ? probe_addr : item_addr;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rdata_q <= mem_q[mem_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_kind_q  <= kind;
			item_pool_q  <= pool;
			item_index_q <= index;
			item_ok_q    <= erase_ok;
			item_ns_q    <= new_state;
		end
		if (cmd.probe_issue) begin
			probe_idx_q <= cur_idx;
		end
		if (cmd.mod_start) begin
			mod_quo_q <= IDX_W'(mod_prod >> RCP_SH);
		end
		if (cmd.mod_step && mod_k_q != '0) begin
			mod_rem_q <= IDX_W'(32'(item_index_q) - mod_back);
		end
		if (cmd.res_load) begin
			res_status_q <= cmd.res_status;
			case (cmd.res_src)
				SRC_ITEM: begin
					res_pool_q  <= item_pool_q;
					res_index_q <= item_index_q;
				end
				SRC_PENDING: begin
					res_pool_q  <= pending_pool_q;
					res_index_q <= IDX_W'(pending_index_q);
				end
				SRC_PROBE: begin
					res_pool_q  <= walk_pool_q;
					res_index_q <= IDX_W'(probe_idx_q);
				end
				default: begin
					res_pool_q  <= walk_pool_q;
					res_index_q <= '0;
				end
			endcase
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_pool_q   <= res_pool_q;
			out_index_q  <= res_index_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < POOLS; p++) begin
				cursor_q[p] <= '0;
			end
			awaiting_q      <= 1'b0;
			pending_pool_q  <= '0;
			pending_index_q <= '0;
			probes_q        <= '0;
			walk_pool_q     <= '0;
			clr_q           <= '0;
			mod_k_q         <= '0;
		end else begin
			if (cmd.clear_step) begin
				clr_q <= AW'(clr_q + 1'b1);
			end
			if (cmd.walk_start) begin
				probes_q    <= '0;
				walk_pool_q <= item_pool_q;
			end
			if (cmd.erase_done) begin
				awaiting_q <= 1'b0;
				if (!item_ok_q) begin
					walk_pool_q <= pending_pool_q;
				end
			end
			if (cmd.probe_issue) begin
				cursor_q[walk_sel] <= cur_next;
				probes_q           <= PRW'(probes_q + 1'b1);
			end else if (cmd.mod_step && mod_k_q == '0) begin
				cursor_q[PW'(item_pool_q)] <= CW'(mod_fix);
			end
			if (cmd.probe_erase) begin
				awaiting_q      <= 1'b1;
				pending_pool_q  <= walk_pool_q;
				pending_index_q <= probe_idx_q;
			end
			if (cmd.mod_start) begin
				mod_k_q <= MODK_W'(1);
			end else if (cmd.mod_step) begin
				mod_k_q <= MODK_W'(mod_k_q - 1'b1);
			end
		end
	end

	always_comb begin
		stat             = '0;
		stat.kind        = item_kind_q;
		stat.pool_ok     = (32'(item_pool_q) < POOLS);
		stat.idx_ok      = (32'(item_index_q) < ENTRIES);
		stat.awaiting    = awaiting_q;
		stat.erase_ok    = item_ok_q;
		stat.probes_full = (probes_q == PRW'(ENTRIES));
		stat.rd_state    = rdata_q;
		stat.mod_last    = (mod_k_q == '0);
		stat.clear_last  = (clr_q == AW'(DEPTH - 1));
	end

	assign status    = out_status_q;
	assign out_pool  = out_pool_q;
	assign out_index = out_index_q;

endmodule

@@ design/flash_block_allocator.sv @@
// Result paths: release, set block state and rejected items go straight to the result; a
// query first reads the block state; set cursor runs a reciprocal-multiply reduction; a walk
// (allocate or failed erase) reads then checks each probe, out of blocks after ENTRIES probes.
// One transaction at a time: the next is accepted after the result enters the output register.
// Reset: arst_n clears control state, then a clearing pass over all POOLS*ENTRIES blocks marks
// every block free while in_ready stays low.
// ----------------------------------------------------------------------------
// Flash block allocator
// Round-robin free block allocator over several pools with erase handshaking.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module flash_block_allocator #(
	parameter int ENTRIES = fba_pkg::ENTRIES_DEF,
	parameter int POOLS   = fba_pkg::POOLS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [fba_pkg::KIND_W-1:0]   kind,
	input  logic [fba_pkg::POOL_W-1:0]   pool,
	input  logic [fba_pkg::IDX_W-1:0]    index,
	input  logic                         erase_ok,
	input  logic [fba_pkg::BS_W-1:0]     new_state,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [fba_pkg::STAT_W-1:0]   status,
	output logic [fba_pkg::POOL_W-1:0]   out_pool,
	output logic [fba_pkg::IDX_W-1:0]    out_index
);
	import fba_pkg::*;

	// The controller and datapath talk only through these two bundles. The
	// controller owns the sequencing and the result valid flag; the datapath
	// owns the block state memory, the per-pool cursors and all payload.
	cmd_t  cmd;
	stat_t stat;

	// The controller decodes each latched transaction, walks a pool one probe
	// at a time (memory read, then check), and parks the finished
	// result in a staging register until the output register is free.
	fba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// The datapath holds one 2-bit state per block in a single-port-write,
	// registered-read memory; a walk resumes from the cursor that the last walk left behind,
	// and a failed erase reply also keeps the probe count of its walk.
	fba_datapath #(
		.ENTRIES (ENTRIES),
		.POOLS   (POOLS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.kind      (kind),
		.pool      (pool),
		.index     (index),
		.erase_ok  (erase_ok),
		.new_state (new_state),
		.status    (status),
		.out_pool  (out_pool),
		.out_index (out_index)
	);

endmodule
